// File: hw/rtl/ckx_pkg.sv
// ----------------------------------------------------------------------------
// ckx_pkg
// Shared constants and types for the canonical k-mer extractor.
// ----------------------------------------------------------------------------
package ckx_pkg;

   localparam int MAX_KMER_DEF = 31;
   localparam int KLEN_W       = 5;
   localparam int KLEN_RESET   = 31;
   localparam int BYTE_W       = 8;
   localparam int KMER_W       = 62;
   localparam int RSP_TDATA_W  = 64;

   localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_GT = 8'h3E;
   localparam logic [BYTE_W-1:0] CHAR_A  = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_C  = 8'h43;
   localparam logic [BYTE_W-1:0] CHAR_G  = 8'h47;
   localparam logic [BYTE_W-1:0] CHAR_T  = 8'h54;

   localparam logic [1:0] BASE_A = 2'd0;
   localparam logic [1:0] BASE_C = 2'd1;
   localparam logic [1:0] BASE_G = 2'd2;
   localparam logic [1:0] BASE_T = 2'd3;

   // per-cycle command to every window cell
   typedef struct packed {
      logic       shift;
      logic       clear;
      logic [1:0] code;
   } ckx_ctl_type;

   typedef struct packed {
      logic       is_base;
      logic [1:0] code;
   } ckx_base_type;

   function automatic ckx_base_type decode_base(input logic [BYTE_W-1:0] b);
      ckx_base_type r;
      r.is_base = 1'b1;
      case (b)
         CHAR_A:  r.code = BASE_A;
         CHAR_C:  r.code = BASE_C;
         CHAR_G:  r.code = BASE_G;
         CHAR_T:  r.code = BASE_T;
         default: begin
            r.is_base = 1'b0;
            r.code    = BASE_A;
         end
      endcase
      return r;
   endfunction

endpackage

// File: hw/rtl/ckx_cell.sv
// ----------------------------------------------------------------------------
// ckx_cell
// One base position of the forward and reverse-complement windows.
// ----------------------------------------------------------------------------
module ckx_cell (
   input  logic                clock,
   input  logic                reset,
   input  ckx_pkg::ckx_ctl_type ctl,
   input  logic                active,
   input  logic                head,
   input  logic [1:0]          fwd_src,
   input  logic [1:0]          rev_src,
   output logic [1:0]          fwd_base,
   output logic [1:0]          rev_base
);
   import ckx_pkg::*;

   logic [1:0] fwd_ff, fwd_in;
   logic [1:0] rev_ff, rev_in;

   always_comb begin
      fwd_in = fwd_ff;
      rev_in = rev_ff;
      if (ctl.clear) begin
         fwd_in = 2'b00;
         rev_in = 2'b00;
      end else if (ctl.shift) begin
         fwd_in = active ? fwd_src : 2'b00;
         if (!active)
            rev_in = 2'b00;
         else if (head)
            rev_in = ~ctl.code;
         else
            rev_in = rev_src;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 2'b00;
         rev_ff <= 2'b00;
      end else begin
         fwd_ff <= fwd_in;
         rev_ff <= rev_in;
      end
   end

   assign fwd_base = fwd_ff;
   assign rev_base = rev_ff;

endmodule

// File: hw/rtl/ckx_ctrl.sv
// ----------------------------------------------------------------------------
// ckx_ctrl
// Line parser, k-mer length register and bases-held counter.
// ----------------------------------------------------------------------------
module ckx_ctrl #(
   parameter int MAX_KMER = ckx_pkg::MAX_KMER_DEF,
   parameter int K_W      = $clog2(MAX_KMER + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_acc,
   input  logic [ckx_pkg::BYTE_W-1:0] req_byte,
   input  logic                       csr_wr_en,
   input  logic [ckx_pkg::KLEN_W-1:0] csr_wr_data,
   output ckx_pkg::ckx_ctl_type       ctl,
   output logic                       emit,
   output logic [K_W-1:0]             k_eff
);
   import ckx_pkg::*;

   localparam int K_RST = (KLEN_RESET > MAX_KMER) ? MAX_KMER : KLEN_RESET;

   logic [K_W-1:0] k_ff, k_in;
   logic [K_W-1:0] held_ff, held_in;
   logic           start_ff, start_in;
   logic           hdr_ff, hdr_in;
   ckx_base_type   base;

   assign base = decode_base(req_byte);

   always_comb begin
      k_in = k_ff;
      if (csr_wr_en) begin
         if (csr_wr_data == '0)
            k_in = K_W'(1);
         else if (int'(csr_wr_data) > MAX_KMER)
            k_in = K_W'(MAX_KMER);
         else
            k_in = K_W'(csr_wr_data);
      end
   end

   always_comb begin
      start_in  = start_ff;
      hdr_in    = hdr_ff;
      ctl.shift = 1'b0;
      ctl.clear = csr_wr_en;
      ctl.code  = base.code;
      if (req_acc) begin
         if (req_byte == CHAR_LF) begin
            start_in  = 1'b1;
            hdr_in    = 1'b0;
            ctl.clear = 1'b1;
         end else if (!hdr_ff) begin
            start_in = 1'b0;
            if (start_ff && req_byte == CHAR_GT)
               hdr_in = 1'b1;
            else if (base.is_base)
               ctl.shift = 1'b1;
            else
               ctl.clear = 1'b1;
         end
      end
   end

   always_comb begin
      held_in = held_ff;
      if (ctl.clear)
         held_in = '0;
      else if (ctl.shift && held_ff < k_ff)
         held_in = held_ff + K_W'(1);
   end

   assign emit  = ctl.shift && !ctl.clear && (held_in == k_ff);
   assign k_eff = k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff     <= K_W'(K_RST);
         held_ff  <= '0;
         start_ff <= 1'b1;
         hdr_ff   <= 1'b0;
      end else begin
         k_ff     <= k_in;
         held_ff  <= held_in;
         start_ff <= start_in;
         hdr_ff   <= hdr_in;
      end
   end

endmodule

// File: hw/rtl/ckx_out.sv
// ----------------------------------------------------------------------------
// ckx_out
// Strand compare and output register for the result channel.
// ----------------------------------------------------------------------------
module ckx_out #(
   parameter int WIN_W = 2 * ckx_pkg::MAX_KMER_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            emit,
   input  logic [WIN_W-1:0]                fwd_win,
   input  logic [WIN_W-1:0]                rev_win,
   output logic                            win_free,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ckx_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [0:0]                      rsp_tuser
);
   import ckx_pkg::*;

   logic             pend_ff, pend_in;
   logic             vld_ff, vld_in;
   logic [KMER_W-1:0] kmer_ff, kmer_in;
   logic             rev_ff, rev_in;
   logic             load;
   logic             rev_lt;
   logic [63:0]      fwd_ext, rev_ext;

   // pending result sits in the window registers until the output slot frees
   assign load     = pend_ff && (!vld_ff || rsp_tready);
   assign win_free = !pend_ff || load;
   assign rev_lt   = rev_win < fwd_win;
   assign fwd_ext  = 64'(fwd_win);
   assign rev_ext  = 64'(rev_win);

   always_comb begin
      pend_in = win_free ? emit : pend_ff;
      vld_in  = vld_ff;
      kmer_in = kmer_ff;
      rev_in  = rev_ff;
      if (load) begin
         vld_in  = 1'b1;
         kmer_in = rev_lt ? rev_ext[KMER_W-1:0] : fwd_ext[KMER_W-1:0];
         rev_in  = rev_lt;
      end else if (rsp_tready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         vld_ff  <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         vld_ff  <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      kmer_ff <= kmer_in;
      rev_ff  <= rev_in;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = RSP_TDATA_W'(kmer_ff);
   assign rsp_tuser  = rev_ff;

endmodule

// File: hw/rtl/canonical_kmer_extractor.sv
// ----------------------------------------------------------------------------
// canonical_kmer_extractor
// Canonical k-mer extraction from FASTA text, one byte per transfer.
// ----------------------------------------------------------------------------
// Takes one text byte per clock with no gaps of its own. Each base moves a row
// of MAX_KMER window cells by one position in the cycle of the transfer; the
// strand compare reads the window cells and its result is registered in the
// output register once that is free, so a k-mer passes from the window cells
// to the output register before it shows on rsp_. A stalled rsp_ holds one
// result in the output register and one in the window cells before req_tready drops.
// Writing csr_ empties the window; header and line tracking are kept.
module canonical_kmer_extractor #(
   parameter int MAX_KMER = ckx_pkg::MAX_KMER_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: [7:0] text_byte
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ckx_pkg::BYTE_W-1:0]      req_tdata,
   // rsp_tdata: [61:0] canonical_kmer, upper bits zero
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ckx_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // rsp_tuser: [0] from_reverse_strand
   output logic [0:0]                      rsp_tuser,
   input  logic                            csr_wr_en,
   input  logic [ckx_pkg::KLEN_W-1:0]      csr_wr_data
);
   import ckx_pkg::*;

   localparam int WIN_W = 2 * MAX_KMER;
   localparam int K_W   = $clog2(MAX_KMER + 1);

   ckx_ctl_type    ctl;
   logic           emit;
   logic           req_acc;
   logic           win_free;
   logic [K_W-1:0] k_eff;
   logic [1:0]     fwd_base [MAX_KMER];
   logic [1:0]     rev_base [MAX_KMER];
   logic [WIN_W-1:0] fwd_win, rev_win;

   assign req_tready = win_free;
   assign req_acc    = req_tvalid && req_tready;

   ckx_ctrl #(
      .MAX_KMER (MAX_KMER),
      .K_W      (K_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_acc     (req_acc),
      .req_byte    (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .ctl         (ctl),
      .emit        (emit),
      .k_eff       (k_eff)
   );

   for (genvar i = 0; i < MAX_KMER; i++) begin : g_cell
      logic [1:0] fwd_src, rev_src;
      logic       active, head;

      if (i == 0) begin : g_first
         assign fwd_src = ctl.code;
      end else begin : g_mid
         assign fwd_src = fwd_base[i-1];
      end
      if (i == MAX_KMER - 1) begin : g_last
         assign rev_src = 2'b00;
      end else begin : g_tail
         assign rev_src = rev_base[i+1];
      end

      assign active = K_W'(i) < k_eff;
      assign head   = K_W'(i + 1) == k_eff;

      ckx_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .active   (active),
         .head     (head),
         .fwd_src  (fwd_src),
         .rev_src  (rev_src),
         .fwd_base (fwd_base[i]),
         .rev_base (rev_base[i])
      );

      assign fwd_win[2*i+1:2*i] = fwd_base[i];
      assign rev_win[2*i+1:2*i] = rev_base[i];
   end

   ckx_out #(
      .WIN_W (WIN_W)
   ) u_out (
      .clock      (clock),
      .reset      (reset),
      .emit       (emit),
      .fwd_win    (fwd_win),
      .rev_win    (rev_win),
      .win_free   (win_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: hw/rtl/ckx_checker.sv
// ----------------------------------------------------------------------------
// ckx_checker
// Port-level checks for the canonical k-mer extractor.
// ----------------------------------------------------------------------------
module ckx_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [ckx_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [0:0]                      rsp_tuser
);
   import ckx_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp payload changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid ##1 !rsp_tvalid)
      else $error("result too soon after reset");

   // a fresh result must follow an input transfer, a held result or a low req_tready
   a_latency: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid ##1 rsp_tvalid |-> $past(req_tvalid && req_tready, 2)
         || $past(rsp_tvalid, 2) || $past(!req_tready, 2))
      else $error("result without a matching input transfer");

endmodule

bind canonical_kmer_extractor ckx_checker u_ckx_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
